[hdl/ccm_pkg.sv]
// Shared types, constants and the microcode table of the contour controller mixer.
// No dependencies; the sequencer, the datapath and the top level import this package.
package ccm_pkg;

    localparam int DEF_VALUE_WIDTH        = 16;
    localparam int DEF_GAIN_FRACTION_BITS = 8;

    localparam int NUM_CONTOURS    = 4;
    localparam int CONTOUR_WIDTH   = 2;
    localparam int GAIN_BITS       = 16;
    localparam int GAIN_REG_WIDTH  = GAIN_BITS * NUM_CONTOURS;
    localparam int MODE_REG_WIDTH  = 2 * NUM_CONTOURS;
    localparam int CFG_DATA_WIDTH  = 64;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int UPC_WIDTH       = 4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_POSITION_GAINS          = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPEED_FEEDBACK_GAINS    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_POSITION_FEEDBACK_GAINS = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPEED_FEEDFORWARD_GAINS = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CONTOUR_MODES           = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DRIVE_UPPER_LIMIT       = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DRIVE_LOWER_LIMIT       = 3'd6;

    // Contour numbers.
    localparam logic [CONTOUR_WIDTH-1:0] CONTOUR_MARCH = 2'd0;
    localparam logic [CONTOUR_WIDTH-1:0] CONTOUR_DEPTH = 2'd1;
    localparam logic [CONTOUR_WIDTH-1:0] CONTOUR_YAW   = 2'd2;
    localparam logic [CONTOUR_WIDTH-1:0] CONTOUR_ROLL  = 2'd3;

    typedef enum logic [1:0] {
        MODE_DIRECT    = 2'd0,
        MODE_STABILIZE = 2'd1,
        MODE_SETTINGS  = 2'd2,
        MODE_OFF       = 2'd3
    } mode_t;

    // Multiplier A operand.
    typedef enum logic [1:0] {
        OPA_MPOS,
        OPA_ACC,
        OPA_MSPD,
        OPA_TSPD
    } opa_sel_t;

    // Multiplier B operand, one gain register per code.
    typedef enum logic [1:0] {
        GAIN_KP,
        GAIN_KV,
        GAIN_KF,
        GAIN_KFF
    } gain_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_TPOS,
        ACC_LOAD_PROD,
        ACC_ADD_PROD,
        ACC_SUB_PROD
    } acc_op_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_SAT,
        RES_PASS
    } res_op_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_IF_PASS
    } jump_t;

    typedef struct packed {
        logic                 mul_en;
        opa_sel_t             opa;
        gain_sel_t            gain;
        acc_op_t              acc_op;
        res_op_t              res_op;
        logic                 mix;
        logic                 last;
        jump_t                jump;
        logic [UPC_WIDTH-1:0] target;
    } ctrl_word_t;

    // Status from the request handshake, the datapath and the output side into the sequencer.
    typedef struct packed {
        logic start;
        logic pass;
        logic out_free;
    } seq_status_t;

    localparam ctrl_word_t CTRL_NOP = '{
        mul_en: 1'b0, opa: OPA_MPOS, gain: GAIN_KP, acc_op: ACC_HOLD,
        res_op: RES_NONE, mix: 1'b0, last: 1'b0, jump: JMP_NEXT, target: '0
    };

    // Program step addresses.
    localparam logic [UPC_WIDTH-1:0] UPC_FIRST    = 4'd0;
    localparam logic [UPC_WIDTH-1:0] UPC_PERR     = 4'd1;
    localparam logic [UPC_WIDTH-1:0] UPC_MUL_KP   = 4'd2;
    localparam logic [UPC_WIDTH-1:0] UPC_PSIG     = 4'd3;
    localparam logic [UPC_WIDTH-1:0] UPC_SERR     = 4'd4;
    localparam logic [UPC_WIDTH-1:0] UPC_SUM      = 4'd5;
    localparam logic [UPC_WIDTH-1:0] UPC_SAT      = 4'd6;
    localparam logic [UPC_WIDTH-1:0] UPC_MIX      = 4'd7;
    localparam logic [UPC_WIDTH-1:0] UPC_PASS     = 4'd8;

    // Microcode table: one control word per step.
    function automatic ctrl_word_t ucode_rom(input logic [UPC_WIDTH-1:0] upc);
        ctrl_word_t w;
        w = CTRL_NOP;
        case (upc)
            UPC_FIRST:
            begin
                // Product mpos*kf, accumulator takes the target position.
                // Direct and off modes leave the arithmetic here.
                w.mul_en = 1'b1;
                w.opa    = OPA_MPOS;
                w.gain   = GAIN_KF;
                w.acc_op = ACC_LOAD_TPOS;
                w.jump   = JMP_IF_PASS;
                w.target = UPC_PASS;
            end
            UPC_PERR:
            begin
                w.acc_op = ACC_SUB_PROD;
            end
            UPC_MUL_KP:
            begin
                w.mul_en = 1'b1;
                w.opa    = OPA_ACC;
                w.gain   = GAIN_KP;
            end
            UPC_PSIG:
            begin
                w.mul_en = 1'b1;
                w.opa    = OPA_MSPD;
                w.gain   = GAIN_KV;
                w.acc_op = ACC_LOAD_PROD;
            end
            UPC_SERR:
            begin
                w.mul_en = 1'b1;
                w.opa    = OPA_TSPD;
                w.gain   = GAIN_KFF;
                w.acc_op = ACC_SUB_PROD;
            end
            UPC_SUM:
            begin
                w.acc_op = ACC_ADD_PROD;
            end
            UPC_SAT:
            begin
                w.res_op = RES_SAT;
            end
            UPC_MIX:
            begin
                w.mix  = 1'b1;
                w.last = 1'b1;
            end
            UPC_PASS:
            begin
                w.res_op = RES_PASS;
                w.jump   = JMP_ALWAYS;
                w.target = UPC_MIX;
            end
            default:
            begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

[hdl/ccm_if.sv]
// Request channel interfaces of the contour controller mixer: item, result, configuration.
// Depends on nothing; item and result value widths follow the VALUE_WIDTH parameter of each instance.
interface ccm_item_if #(
    parameter int VALUE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    contour_index;
    logic signed [VALUE_WIDTH-1:0] measured_position;
    logic signed [VALUE_WIDTH-1:0] measured_speed;
    logic signed [VALUE_WIDTH-1:0] target_position;
    logic signed [VALUE_WIDTH-1:0] target_speed;

    modport source (
        output valid, contour_index, measured_position, measured_speed,
               target_position, target_speed,
        input  ready
    );
    modport sink (
        input  valid, contour_index, measured_position, measured_speed,
               target_position, target_speed,
        output ready
    );
endinterface

interface ccm_result_if #(
    parameter int VALUE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] contour_output;
    logic signed [VALUE_WIDTH-1:0] vertical_right;
    logic signed [VALUE_WIDTH-1:0] vertical_left;
    logic signed [VALUE_WIDTH-1:0] horizontal_right_front;
    logic signed [VALUE_WIDTH-1:0] horizontal_right_back;
    logic signed [VALUE_WIDTH-1:0] horizontal_left_front;
    logic signed [VALUE_WIDTH-1:0] horizontal_left_back;

    modport source (
        output valid, contour_output, vertical_right, vertical_left,
               horizontal_right_front, horizontal_right_back,
               horizontal_left_front, horizontal_left_back,
        input  ready
    );
    modport sink (
        input  valid, contour_output, vertical_right, vertical_left,
               horizontal_right_front, horizontal_right_back,
               horizontal_left_front, horizontal_left_back,
        output ready
    );
endinterface

interface ccm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hdl/ccm_sequencer.sv]
// Microcode sequencer: step counter, table lookup and conditional and unconditional jumps.
// Depends on ccm_pkg for the control word and the microcode table.
module ccm_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  ccm_pkg::seq_status_t status,
    output ccm_pkg::ctrl_word_t  ctrl,
    output logic                busy
);
    import ccm_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t               state_reg, state_next;
    logic [UPC_WIDTH-1:0] upc_reg, upc_next;
    ctrl_word_t           word;
    logic                 stall;

    always_comb
    begin
        word       = ucode_rom(upc_reg);
        // The mix step loads the result register, so it waits for that to be free.
        stall      = word.mix && !status.out_free;
        state_next = state_reg;
        upc_next   = upc_reg;
        ctrl       = CTRL_NOP;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.start)
                begin
                    state_next = ST_RUN;
                    upc_next   = UPC_FIRST;
                end
            end
            ST_RUN:
            begin
                if (!stall)
                begin
                    ctrl = word;
                    if (word.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (word.jump == JMP_ALWAYS ||
                             (word.jump == JMP_IF_PASS && status.pass))
                    begin
                        upc_next = word.target;
                    end
                    else
                    begin
                        upc_next = upc_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            upc_reg   <= UPC_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            upc_reg   <= upc_next;
        end
    end

    assign busy = (state_reg == ST_RUN);

endmodule

[hdl/ccm_datapath.sv]
// Datapath: input latch, shared gain multiplier, accumulator, contour store and mixer.
// Depends on ccm_pkg; driven one control word per cycle by ccm_sequencer, a no-op word while it idles or stalls.
module ccm_datapath #(
    parameter int VALUE_WIDTH        = ccm_pkg::DEF_VALUE_WIDTH,
    parameter int GAIN_FRACTION_BITS = ccm_pkg::DEF_GAIN_FRACTION_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ccm_pkg::ctrl_word_t                 ctrl,
    input  logic                                load,
    input  logic [ccm_pkg::CONTOUR_WIDTH-1:0]   contour_index,
    input  logic signed [VALUE_WIDTH-1:0]       measured_position,
    input  logic signed [VALUE_WIDTH-1:0]       measured_speed,
    input  logic signed [VALUE_WIDTH-1:0]       target_position,
    input  logic signed [VALUE_WIDTH-1:0]       target_speed,
    input  logic [ccm_pkg::GAIN_REG_WIDTH-1:0]  position_gains,
    input  logic [ccm_pkg::GAIN_REG_WIDTH-1:0]  speed_feedback_gains,
    input  logic [ccm_pkg::GAIN_REG_WIDTH-1:0]  position_feedback_gains,
    input  logic [ccm_pkg::GAIN_REG_WIDTH-1:0]  speed_feedforward_gains,
    input  logic [ccm_pkg::MODE_REG_WIDTH-1:0]  contour_modes,
    input  logic signed [VALUE_WIDTH-1:0]       drive_upper_limit,
    input  logic signed [VALUE_WIDTH-1:0]       drive_lower_limit,
    output logic                                pass,
    output logic signed [VALUE_WIDTH-1:0]       contour_output,
    output logic signed [VALUE_WIDTH-1:0]       vertical_right,
    output logic signed [VALUE_WIDTH-1:0]       vertical_left,
    output logic signed [VALUE_WIDTH-1:0]       horizontal_right,
    output logic signed [VALUE_WIDTH-1:0]       horizontal_left
);
    import ccm_pkg::*;

    // The position error always fits VALUE_WIDTH+16 bits; the accumulator has two spare bits.
    localparam int OPA_WIDTH  = VALUE_WIDTH + GAIN_BITS;
    localparam int PROD_WIDTH = OPA_WIDTH + GAIN_BITS;
    localparam int ACC_WIDTH  = PROD_WIDTH + 2;
    localparam int SUM_WIDTH  = VALUE_WIDTH + 1;

    logic [CONTOUR_WIDTH-1:0]      idx_reg;
    logic signed [VALUE_WIDTH-1:0] mpos_reg, mspd_reg, tpos_reg, tspd_reg;
    logic signed [PROD_WIDTH-1:0]  prod_reg;
    logic signed [ACC_WIDTH-1:0]   acc_reg;
    logic signed [VALUE_WIDTH-1:0] store_reg [NUM_CONTOURS];
    logic signed [VALUE_WIDTH-1:0] ctl_reg;
    logic signed [VALUE_WIDTH-1:0] result_reg, vr_reg, vl_reg, hr_reg, hl_reg;

    mode_t                        mode;
    logic [GAIN_REG_WIDTH-1:0]    gain_word;
    logic signed [GAIN_BITS-1:0]  gain;
    logic signed [OPA_WIDTH-1:0]  opa;
    logic signed [PROD_WIDTH-1:0] prod_shift;
    logic signed [ACC_WIDTH-1:0]  prod_ext;
    logic                         acc_in_range;
    logic signed [VALUE_WIDTH-1:0] sat_value, pass_value, res_value;
    logic signed [SUM_WIDTH-1:0]  depth_ext, roll_ext, march_ext, yaw_ext;
    logic signed [SUM_WIDTH-1:0]  vr_clamp, vl_clamp, hr_clamp, hl_clamp;

    function automatic logic signed [SUM_WIDTH-1:0] clamp_drive(
        input logic signed [SUM_WIDTH-1:0] x
    );
        logic signed [SUM_WIDTH-1:0] up;
        logic signed [SUM_WIDTH-1:0] dn;
        logic signed [SUM_WIDTH-1:0] r;
        up = SUM_WIDTH'(drive_upper_limit);
        dn = SUM_WIDTH'(drive_lower_limit);
        r  = x;
        if (x <= dn)
        begin
            r = dn;
        end
        // The upper limit wins when the limits cross.
        if (x >= up)
        begin
            r = up;
        end
        return r;
    endfunction

    assign mode = mode_t'(contour_modes[{idx_reg, 1'b0} +: 2]);
    assign pass = !(mode == MODE_STABILIZE || mode == MODE_SETTINGS);

    always_comb
    begin
        case (ctrl.gain)
            GAIN_KP:  gain_word = position_gains;
            GAIN_KV:  gain_word = speed_feedback_gains;
            GAIN_KF:  gain_word = position_feedback_gains;
            GAIN_KFF: gain_word = speed_feedforward_gains;
            default:  gain_word = position_gains;
        endcase
        gain = $signed(gain_word[{idx_reg, 4'b0000} +: GAIN_BITS]);

        case (ctrl.opa)
            OPA_MPOS: opa = OPA_WIDTH'(mpos_reg);
            OPA_ACC:  opa = $signed(acc_reg[OPA_WIDTH-1:0]);
            OPA_MSPD: opa = OPA_WIDTH'(mspd_reg);
            OPA_TSPD: opa = OPA_WIDTH'(tspd_reg);
            default:  opa = OPA_WIDTH'(mpos_reg);
        endcase
    end

    // Each gain product is floored by the gain fraction bits.
    assign prod_shift = prod_reg >>> GAIN_FRACTION_BITS;
    assign prod_ext   = ACC_WIDTH'(prod_shift);

    // Saturation: in range when all bits above the value's sign bit match it.
    assign acc_in_range = (acc_reg[ACC_WIDTH-1:VALUE_WIDTH-1] == '0) ||
                          (acc_reg[ACC_WIDTH-1:VALUE_WIDTH-1] == '1);
    assign sat_value  = acc_in_range ? acc_reg[VALUE_WIDTH-1:0]
                      : (acc_reg[ACC_WIDTH-1] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                              : {1'b0, {(VALUE_WIDTH-1){1'b1}}});
    assign pass_value = (mode == MODE_DIRECT) ? tspd_reg : '0;
    assign res_value  = (ctrl.res_op == RES_PASS) ? pass_value : sat_value;

    assign march_ext = SUM_WIDTH'(store_reg[CONTOUR_MARCH]);
    assign depth_ext = SUM_WIDTH'(store_reg[CONTOUR_DEPTH]);
    assign yaw_ext   = SUM_WIDTH'(store_reg[CONTOUR_YAW]);
    assign roll_ext  = SUM_WIDTH'(store_reg[CONTOUR_ROLL]);
    assign vr_clamp  = clamp_drive(depth_ext + roll_ext);
    assign vl_clamp  = clamp_drive(depth_ext - roll_ext);
    assign hr_clamp  = clamp_drive(march_ext + yaw_ext);
    assign hl_clamp  = clamp_drive(march_ext - yaw_ext);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            idx_reg  <= contour_index;
            mpos_reg <= measured_position;
            mspd_reg <= measured_speed;
            tpos_reg <= target_position;
            tspd_reg <= target_speed;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= PROD_WIDTH'(opa) * PROD_WIDTH'(gain);
        end
        case (ctrl.acc_op)
            ACC_HOLD:      acc_reg <= acc_reg;
            ACC_LOAD_TPOS: acc_reg <= ACC_WIDTH'(tpos_reg);
            ACC_LOAD_PROD: acc_reg <= prod_ext;
            ACC_ADD_PROD:  acc_reg <= acc_reg + prod_ext;
            ACC_SUB_PROD:  acc_reg <= acc_reg - prod_ext;
            default:       acc_reg <= acc_reg;
        endcase
        // The controller output is held apart from the result register, so a
        // result that still waits at the output keeps its value.
        if (ctrl.res_op != RES_NONE)
        begin
            ctl_reg <= res_value;
        end
        if (ctrl.mix)
        begin
            result_reg <= ctl_reg;
            vr_reg     <= vr_clamp[VALUE_WIDTH-1:0];
            vl_reg     <= vl_clamp[VALUE_WIDTH-1:0];
            hr_reg     <= hr_clamp[VALUE_WIDTH-1:0];
            hl_reg     <= hl_clamp[VALUE_WIDTH-1:0];
        end
    end

    // Stored contour outputs reset to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CONTOURS; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (ctrl.res_op != RES_NONE)
        begin
            store_reg[idx_reg] <= res_value;
        end
    end

    assign contour_output   = result_reg;
    assign vertical_right   = vr_reg;
    assign vertical_left    = vl_reg;
    assign horizontal_right = hr_reg;
    assign horizontal_left  = hl_reg;

endmodule

[hdl/cascaded_contour_controller_mixer.sv]
// Top level of the cascaded contour controller with thruster mixer.
// Depends on ccm_pkg, the channel interfaces in ccm_if.sv, ccm_sequencer and ccm_datapath.
//
//  Channel  | Direction | Handshake    | Payload
//  ---------+-----------+--------------+-----------------------------------------------
//  item     | in        | valid/ready  | contour_index, measured/target position+speed
//  result   | out       | valid/ready  | contour_output and six thruster drives
//  cfg      | in        | valid/ready  | index (3 bits), data (64 bits)
//
// A stabilize or settings request runs from the first step to mix, with four products of
// the shared 16-bit-gain multiplier in sequence, at most one per step; a direct or off
// request jumps from the first step to pass, then mix; the microcode program sets both.
// Reset (rst_n low, asynchronous) restores the register defaults, clears the four stored
// contour outputs and leaves the sequencer idle with no result pending.
// A new request is taken whenever the sequencer is idle, even while a result waits; the
// program stalls at its final mix step only if the previous result has not yet gone out.
// Configuration is always ready; writes to indexes above six are dropped.
module cascaded_contour_controller_mixer #(
    parameter int VALUE_WIDTH        = ccm_pkg::DEF_VALUE_WIDTH,
    parameter int GAIN_FRACTION_BITS = ccm_pkg::DEF_GAIN_FRACTION_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    ccm_item_if.sink            item,
    ccm_result_if.source        result,
    ccm_cfg_if.sink             cfg
);
    import ccm_pkg::*;

    // Configuration registers.
    logic [GAIN_REG_WIDTH-1:0]     position_gains_reg;
    logic [GAIN_REG_WIDTH-1:0]     speed_feedback_gains_reg;
    logic [GAIN_REG_WIDTH-1:0]     position_feedback_gains_reg;
    logic [GAIN_REG_WIDTH-1:0]     speed_feedforward_gains_reg;
    logic [MODE_REG_WIDTH-1:0]     contour_modes_reg;
    logic signed [VALUE_WIDTH-1:0] drive_upper_limit_reg;
    logic signed [VALUE_WIDTH-1:0] drive_lower_limit_reg;

    logic        out_valid_reg, out_valid_next;
    logic        busy;
    logic        start;
    logic        pass;
    seq_status_t status;
    ctrl_word_t  ctrl;

    logic signed [VALUE_WIDTH-1:0] horizontal_right;
    logic signed [VALUE_WIDTH-1:0] horizontal_left;

    // A request is taken only while no program runs.
    assign item.ready = !busy;
    assign start      = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    assign status.start    = start;
    assign status.pass     = pass;
    assign status.out_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_gains_reg          <= '0;
            speed_feedback_gains_reg    <= '0;
            position_feedback_gains_reg <= '0;
            speed_feedforward_gains_reg <= '0;
            contour_modes_reg           <= '0;
            drive_upper_limit_reg       <= {1'b0, {(VALUE_WIDTH-1){1'b1}}};
            drive_lower_limit_reg       <= {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_POSITION_GAINS:
                    position_gains_reg <= cfg.data[GAIN_REG_WIDTH-1:0];
                REG_SPEED_FEEDBACK_GAINS:
                    speed_feedback_gains_reg <= cfg.data[GAIN_REG_WIDTH-1:0];
                REG_POSITION_FEEDBACK_GAINS:
                    position_feedback_gains_reg <= cfg.data[GAIN_REG_WIDTH-1:0];
                REG_SPEED_FEEDFORWARD_GAINS:
                    speed_feedforward_gains_reg <= cfg.data[GAIN_REG_WIDTH-1:0];
                REG_CONTOUR_MODES:
                    contour_modes_reg <= cfg.data[MODE_REG_WIDTH-1:0];
                REG_DRIVE_UPPER_LIMIT:
                    drive_upper_limit_reg <= cfg.data[VALUE_WIDTH-1:0];
                REG_DRIVE_LOWER_LIMIT:
                    drive_lower_limit_reg <= cfg.data[VALUE_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The result is valid from the mix step until the sink takes it. When a new result
    // is mixed in the same cycle that the old one leaves, valid simply stays high.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctrl.mix)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    ccm_sequencer u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    ccm_datapath #(
        .VALUE_WIDTH        (VALUE_WIDTH),
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_datapath (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .ctrl                    (ctrl),
        .load                    (start),
        .contour_index           (item.contour_index),
        .measured_position       (item.measured_position),
        .measured_speed          (item.measured_speed),
        .target_position         (item.target_position),
        .target_speed            (item.target_speed),
        .position_gains          (position_gains_reg),
        .speed_feedback_gains    (speed_feedback_gains_reg),
        .position_feedback_gains (position_feedback_gains_reg),
        .speed_feedforward_gains (speed_feedforward_gains_reg),
        .contour_modes           (contour_modes_reg),
        .drive_upper_limit       (drive_upper_limit_reg),
        .drive_lower_limit       (drive_lower_limit_reg),
        .pass                    (pass),
        .contour_output          (result.contour_output),
        .vertical_right          (result.vertical_right),
        .vertical_left           (result.vertical_left),
        .horizontal_right        (horizontal_right),
        .horizontal_left         (horizontal_left)
    );

    // Front and back thrusters on each side receive the same drive.
    assign result.valid                  = out_valid_reg;
    assign result.horizontal_right_front = horizontal_right;
    assign result.horizontal_right_back  = horizontal_right;
    assign result.horizontal_left_front  = horizontal_left;
    assign result.horizontal_left_back   = horizontal_left;

endmodule
